[rtl/core/zscore_sigmoid_anomaly_scorer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the z-score anomaly scorer
// Clocked on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ZSCORE_SIGMOID_ANOMALY_SCORER_ASSERT_SVH
`define ZSCORE_SIGMOID_ANOMALY_SCORER_ASSERT_SVH

// Same-cycle property.
`define ZSSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent this cycle, consequent next cycle.
`define ZSSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/zssa_pkg.sv]
// ----------------------------------------------------------------------------
// zssa_pkg
// Shared constants and types of the z-score anomaly scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package zssa_pkg;

  localparam int unsigned SigEntriesDef = 256;
  localparam logic [15:0] ThrReset      = 16'd768;   // 3.0 in Q8.8
  localparam logic [15:0] ZSat          = 16'hFFFF;
  localparam logic [15:0] ZTen          = 16'd2560;  // 10.0 in Q8.8
  localparam logic [9:0]  ValueEps      = 10'd655;   // 0.01 in Q16.16
  localparam logic [9:0]  RateEps       = 10'd65;    // 0.001 in Q16.16
  localparam int          SigSpan       = 2560;      // 10.0 in Q8.8
  localparam logic [15:0] ScoreOne      = 16'hFFFF;
  localparam logic [15:0] Recip5        = 16'd52429; // 2^18 / 5, rounded up
  localparam int unsigned LaneLat       = 13;        // register stages per lane

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] mean;
    logic [30:0]        dev;
  } lane_in_t;

  typedef struct packed {
    logic [15:0] z;
    logic [15:0] score;
  } lane_out_t;

endpackage

`default_nettype wire

[rtl/core/zssa_if.sv]
// ----------------------------------------------------------------------------
// zssa_in_if / zssa_out_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface zssa_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [7:0]         channel_index;
  logic               baseline_valid;
  logic signed [31:0] sample_value;
  logic signed [31:0] value_mean;
  logic [30:0]        value_deviation;
  logic signed [31:0] rate_value;
  logic signed [31:0] rate_mean;
  logic [30:0]        rate_deviation;

  modport source (
    output valid, req_type, channel_index, baseline_valid, sample_value, value_mean,
           value_deviation, rate_value, rate_mean, rate_deviation,
    input  ready
  );
  modport sink (
    input  valid, req_type, channel_index, baseline_valid, sample_value, value_mean,
           value_deviation, rate_value, rate_mean, rate_deviation,
    output ready
  );
endinterface

interface zssa_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  result_channel;
  logic [15:0] value_zscore;
  logic [15:0] rate_zscore;
  logic [15:0] value_score;
  logic [15:0] rate_score;
  logic [15:0] combined_score;

  modport source (
    output valid, result_channel, value_zscore, rate_zscore, value_score, rate_score,
           combined_score,
    input  ready
  );
  modport sink (
    input  valid, result_channel, value_zscore, rate_zscore, value_score, rate_score,
           combined_score,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/zssa_lane.sv]
// ----------------------------------------------------------------------------
// zssa_lane
// One quantity: |x - mean| / dev as Q8.8 (2 quotient bits per stage), then
// sigmoid index and registered ROM lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module zssa_lane #(
  parameter int unsigned SigEntries = zssa_pkg::SigEntriesDef
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [9:0]         eps_i,
  input  wire logic [15:0]        thr_i,
  input  wire zssa_pkg::lane_in_t in_i,
  output zssa_pkg::lane_out_t     out_o
);
  import zssa_pkg::*;

  localparam int unsigned IdxW = $clog2(SigEntries);
  localparam int unsigned Den  = SigEntries - 1;
  localparam int unsigned TW   = 14 + IdxW;
  localparam int unsigned YW   = TW - 10;
  localparam int unsigned PW   = YW + 16;
  localparam logic [63:0] Q32  = 64'h1_0000_0000;

  typedef logic [15:0] rom_t [SigEntries];

  // unsigned 64-bit divide, elaboration only (ROM build)
  function automatic logic [63:0] cdiv(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f) in Q32, truncating Taylor series
  function automatic logic [63:0] exp_neg_frac(logic [63:0] f);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = Q32;
    term = Q32;
    for (int k = 1; k <= 20; k++) begin
      term = cdiv((term * f) >> 32, 64'(k));
      if ((k & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [15:0] rom_entry(int idx);
    longint      sn;
    logic        neg;
    logic [63:0] num;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] half;
    logic [63:0] e1;
    logic [63:0] r;
    logic [63:0] dsum;
    logic [63:0] s;
    sn    = 40 * longint'(idx) - 20 * longint'(Den);
    neg   = sn < 0;
    num   = neg ? 64'(-sn) : 64'(sn);
    whole = cdiv(num, 64'(Den));
    frac  = cdiv((num - whole * 64'(Den)) << 32, 64'(Den));
    half  = exp_neg_frac(Q32 >> 1);
    e1    = (half * half) >> 32;
    r     = exp_neg_frac(frac);
    for (int w = 0; w < 32; w++) begin
      if (64'(w) < whole) begin
        r = (r * e1) >> 32;
      end
    end
    dsum = Q32 + r;
    s    = cdiv((64'(ScoreOne) << 32) + (dsum >> 1), dsum);
    if (s > 64'(ScoreOne)) begin
      s = 64'(ScoreOne);
    end
    return neg ? ScoreOne - s[15:0] : s[15:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < SigEntries; i++) begin
      t[i] = rom_entry(i);
    end
    return t;
  endfunction

  localparam rom_t SigRom = build_rom();

  // restoring step: returns {quotient bit, new remainder}
  function automatic logic [31:0] div_step(logic [30:0] rem, logic [30:0] dv, logic nb);
    logic [31:0] s;
    s = {rem, nb};
    if (s >= {1'b0, dv}) begin
      return {1'b1, 31'(s - {1'b0, dv})};
    end
    return {1'b0, s[30:0]};
  endfunction

  // stage A: magnitude
  logic signed [32:0] diff;
  logic [32:0]        mag_d, mag_q;
  logic [30:0]        deva_q;

  assign diff  = {in_i.x[31], in_i.x} - {in_i.mean[31], in_i.mean};
  assign mag_d = diff[32] ? 33'(-diff) : 33'(diff);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      deva_q <= in_i.dev;
    end
  end

  // stage B plus 8 divide stages, index 0 is stage B
  logic        spc_q [9];
  logic [15:0] zsp_q [9];
  logic [30:0] rem_q [9];
  logic [30:0] dv_q  [9];
  logic [15:0] nlo_q [9];
  logic [15:0] quo_q [9];

  logic        zero_dev, sat;
  logic [15:0] zsp_d;

  assign zero_dev = (deva_q == '0);
  assign sat      = {6'b0, mag_q} >= {deva_q, 8'b0};
  assign zsp_d    = zero_dev ? ((mag_q > 33'(eps_i)) ? ZTen : 16'd0) : ZSat;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spc_q[0] <= zero_dev | sat;
      zsp_q[0] <= zsp_d;
      rem_q[0] <= {6'b0, mag_q[32:8]};
      dv_q[0]  <= deva_q;
      nlo_q[0] <= {mag_q[7:0], 8'b0};
      quo_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_div
    logic [31:0] st1, st0;
    assign st1 = div_step(rem_q[j], dv_q[j], nlo_q[j][15]);
    assign st0 = div_step(st1[30:0], dv_q[j], nlo_q[j][14]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        spc_q[j+1] <= spc_q[j];
        zsp_q[j+1] <= zsp_q[j];
        rem_q[j+1] <= st0[30:0];
        dv_q[j+1]  <= dv_q[j];
        nlo_q[j+1] <= {nlo_q[j][13:0], 2'b00};
        quo_q[j+1] <= {quo_q[j][13:0], st1[31], st0[31]};
      end
    end
  end

  // SG1: offset from threshold, scaled index numerator
  logic [15:0]        zdiv;
  logic signed [16:0] dlt;
  logic [16:0]        dpos;
  logic [TW-1:0]      t_d, t1_q;
  logic [15:0]        z1_q, z2_q, z3_q;
  logic               lo1_q, hi1_q, lo2_q, hi2_q;

  assign zdiv = spc_q[8] ? zsp_q[8] : quo_q[8];
  assign dlt  = $signed({1'b0, zdiv}) - $signed({1'b0, thr_i});
  assign dpos = 17'(dlt + 17'sd2560);
  assign t_d  = TW'(dpos[12:0]) * TW'(Den) + TW'(SigSpan);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z1_q  <= zdiv;
      lo1_q <= dlt < -17'sd2560;
      hi1_q <= dlt > 17'sd2560;
      t1_q  <= t_d;
    end
  end

  // SG2: divide by 5120 as shift and reciprocal of 5
  logic [PW-1:0]   prod;
  logic [PW-1:0]   q5;
  logic [IdxW-1:0] idx_d, idx2_q;

  assign prod  = PW'(t1_q[TW-1:10]) * PW'(Recip5);
  assign q5    = prod >> 18;
  assign idx_d = (q5 > PW'(Den)) ? IdxW'(Den) : q5[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z2_q   <= z1_q;
      lo2_q  <= lo1_q;
      hi2_q  <= hi1_q;
      idx2_q <= idx_d;
    end
  end

  // SG3: ROM read
  logic [15:0] score3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z3_q <= z2_q;
      if (lo2_q) begin
        score3_q <= '0;
      end else if (hi2_q) begin
        score3_q <= ScoreOne;
      end else begin
        score3_q <= SigRom[idx2_q];
      end
    end
  end

  assign out_o.z     = z3_q;
  assign out_o.score = score3_q;

endmodule

`default_nettype wire

[rtl/core/zscore_sigmoid_anomaly_scorer.sv]
// ----------------------------------------------------------------------------
// zscore_sigmoid_anomaly_scorer
// Z-score of a sample and its rate against a baseline, mapped through a
// sigmoid ROM to Q0.16 anomaly scores; combined score is the larger one.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake        Word
//  in_i      in   valid/ready      request: type, channel, baseline, 6 operands
//  out_o     out  valid/ready      result: channel, 2 z-scores, 3 scores
//  cfg       in   cfg_we_i only    z_threshold, Q8.8
//
//  One request word per cycle sustained while out_o is not stalled; an accepted
//  word passes the 13 lane stages and then the output register before it shows
//  on out_o. Depth is set by the restoring divider, two quotient bits per stage.
//  The whole pipeline advances together: it moves when the output register is
//  empty or being taken, so a stall on out_o freezes every stage in place.
//  Reset clears stage valid bits and loads z_threshold with 3.0.
//
// ----------------------------------------------------------------------------
`default_nettype none

module zscore_sigmoid_anomaly_scorer #(
  parameter int unsigned SigEntries = zssa_pkg::SigEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  zssa_in_if.sink          in_i,
  zssa_out_if.source       out_o
);
  import zssa_pkg::*;

  `include "zscore_sigmoid_anomaly_scorer_assert.svh"

  // threshold register
  logic [15:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // global advance: output slot free or being drained
  logic ovld_q;
  logic pipe_en;

  assign pipe_en    = !ovld_q || out_o.ready;
  assign in_i.ready = pipe_en;

  // side-band travelling next to the lanes
  logic [LaneLat-1:0] vld_q;
  logic [7:0]         chan_q [LaneLat];
  logic               rtyp_q [LaneLat];
  logic               bv_q   [LaneLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[LaneLat-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      chan_q[0] <= in_i.channel_index;
      rtyp_q[0] <= in_i.req_type;
      bv_q[0]   <= in_i.baseline_valid;
      for (int s = 1; s < LaneLat; s++) begin
        chan_q[s] <= chan_q[s-1];
        rtyp_q[s] <= rtyp_q[s-1];
        bv_q[s]   <= bv_q[s-1];
      end
    end
  end

  // two lanes of the same module, differing only in eps: value and rate
  lane_in_t  vin, rin;
  lane_out_t vout, rout;

  assign vin.x    = in_i.sample_value;
  assign vin.mean = in_i.value_mean;
  assign vin.dev  = in_i.value_deviation;
  assign rin.x    = in_i.rate_value;
  assign rin.mean = in_i.rate_mean;
  assign rin.dev  = in_i.rate_deviation;

  zssa_lane #(.SigEntries(SigEntries)) u_value (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .eps_i  (ValueEps),
    .thr_i  (thr_q),
    .in_i   (vin),
    .out_o  (vout)
  );

  zssa_lane #(.SigEntries(SigEntries)) u_rate (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .eps_i  (RateEps),
    .thr_i  (thr_q),
    .in_i   (rin),
    .out_o  (rout)
  );

  // masking: invalid baseline zeroes all, value-only zeroes the rate side
  logic        use_v, use_r;
  logic [15:0] vz_d, rz_d, vs_d, rs_d, cs_d;

  assign use_v = bv_q[LaneLat-1];
  assign use_r = bv_q[LaneLat-1] && rtyp_q[LaneLat-1];
  assign vz_d  = use_v ? vout.z : 16'd0;
  assign vs_d  = use_v ? vout.score : 16'd0;
  assign rz_d  = use_r ? rout.z : 16'd0;
  assign rs_d  = use_r ? rout.score : 16'd0;
  assign cs_d  = (rs_d > vs_d) ? rs_d : vs_d;

  // output register
  logic [7:0]  ochan_q;
  logic [15:0] ovz_q, orz_q, ovs_q, ors_q, ocs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (pipe_en) begin
      ovld_q <= vld_q[LaneLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ochan_q <= chan_q[LaneLat-1];
      ovz_q   <= vz_d;
      orz_q   <= rz_d;
      ovs_q   <= vs_d;
      ors_q   <= rs_d;
      ocs_q   <= cs_d;
    end
  end

  assign out_o.valid          = ovld_q;
  assign out_o.result_channel = ochan_q;
  assign out_o.value_zscore   = ovz_q;
  assign out_o.rate_zscore    = orz_q;
  assign out_o.value_score    = ovs_q;
  assign out_o.rate_score     = ors_q;
  assign out_o.combined_score = ocs_q;

  // combined score covers both lane scores
  logic comb_ok;

  assign comb_ok = (ocs_q >= ovs_q) && (ocs_q >= ors_q);

  `ZSSA_ASSERT(a_comb_is_max, !out_o.valid || comb_ok, "combined score below a lane score")
  `ZSSA_ASSERT_NEXT(a_stall_freezes, !pipe_en, $stable(vld_q), "pipeline moved during stall")
  `ZSSA_ASSERT_NEXT(a_accept_enters, in_i.valid && in_i.ready, vld_q[0], "accepted word not in stage 0")

endmodule

`default_nettype wire
